// ----- hw/rtl/pidtr_pkg.sv -----
package pidtr_pkg;

  // field and datapath widths
  localparam int RAW_W      = 12;
  localparam int SP_W       = 9;
  localparam int GAIN_W     = 16;
  localparam int LIM_W      = 16;
  localparam int PWR_W      = 17;
  localparam int TEMP_W     = 17;
  localparam int ERR_W      = 19;
  localparam int SUM_W      = 18;
  localparam int DER_W      = 19;
  localparam int WIDE_W     = 20;
  localparam int ACC_W      = 36;

  // sensor conversion: q = (raw * 84480 + 2047) / 4095, done as a serial divide
  localparam int NUM_W      = 29;
  localparam int QUO_W      = 17;
  localparam int REM_W      = NUM_W - QUO_W;
  localparam logic [REM_W-1:0] DIV_DEN   = REM_W'(4095);
  localparam logic [NUM_W-1:0] CONV_BIAS = NUM_W'(2047);

  localparam logic signed [TEMP_W-1:0] TEMP_OFS = TEMP_W'(25600);
  localparam int TEMP_MIN = -58880;
  localparam int TEMP_MAX = 25600;
  localparam logic [PWR_W-1:0] FULL_POWER = PWR_W'(65536);

  // round half up on the 2^-24 product sum
  localparam int PWR_SHIFT = 8;
  localparam logic [ACC_W-2:0] PWR_RND = (ACC_W-1)'(128);

  // stream and config port widths
  localparam int S_TDATA_W  = 16;
  localparam int S_TUSER_W  = 1;
  localparam int M_TDATA_W  = 40;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SETPOINT  = 3'd0,
    CFG_GAIN_PROP = 3'd1,
    CFG_GAIN_INT  = 3'd2,
    CFG_GAIN_DER  = 3'd3,
    CFG_INT_LIMIT = 3'd4,
    CFG_POWER_CAP = 3'd5
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_MUL  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_e;

  typedef struct packed {
    logic [GAIN_W-1:0] prop;
    logic [GAIN_W-1:0] integ;
    logic [GAIN_W-1:0] deriv;
  } gains_t;

  typedef struct packed {
    logic signed [ERR_W-1:0] err;
    logic signed [SUM_W-1:0] sum;
    logic signed [DER_W-1:0] deriv;
  } mac_ops_t;

  // raw * 84480 + 2047, with 84480 = 2^16 + 2^14 + 2^11 + 2^9
  function automatic logic [NUM_W-1:0] conv_num(input logic [RAW_W-1:0] raw);
    logic [NUM_W-1:0] r;
    r = NUM_W'(raw);
    return (r << 16) + (r << 14) + (r << 11) + (r << 9) + CONV_BIAS;
  endfunction

endpackage

// ----- hw/rtl/pidtr_div.sv -----
module pidtr_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [pidtr_pkg::NUM_W-1:0] num_i,
  output logic                        done_o,
  output logic [pidtr_pkg::QUO_W-1:0] quot_o
);
  import pidtr_pkg::*;

  localparam int CNT_W = $clog2(QUO_W + 1);

  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;
  logic [REM_W-1:0] rem_q, rem_d;
  logic [QUO_W-1:0] sh_q;
  logic [REM_W:0]   trial;
  logic             qbit;

  // restoring divide, one quotient bit per cycle; dividend bits shift out of
  // sh_q as quotient bits shift in
  always_comb begin
    trial = {rem_q, sh_q[QUO_W-1]};
    qbit  = trial >= {1'b0, DIV_DEN};
    rem_d = qbit ? REM_W'(trial - {1'b0, DIV_DEN}) : trial[REM_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(QUO_W);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i[NUM_W-1:QUO_W];
      sh_q  <= num_i[QUO_W-1:0];
    end else if (busy_q && cnt_q != '0) begin
      rem_q <= rem_d;
      sh_q  <= {sh_q[QUO_W-2:0], qbit};
    end
  end

  assign done_o = busy_q && (cnt_q == '0);
  assign quot_o = sh_q;

endmodule

// ----- hw/rtl/pidtr_mac.sv -----
module pidtr_mac (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  pidtr_pkg::gains_t                  gains_i,
  input  pidtr_pkg::mac_ops_t                ops_i,
  output logic                               done_o,
  output logic signed [pidtr_pkg::ACC_W-1:0] acc_o
);
  import pidtr_pkg::*;

  localparam int CNT_W = $clog2(GAIN_W + 1);

  logic                    busy_q;
  logic [CNT_W-1:0]        cnt_q;
  gains_t                  g_q;
  mac_ops_t                ops_q;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic signed [ACC_W-1:0] t_prop, t_int, t_der;

  // shift-add over the gain bits, MSB first; the three products share one accumulator
  always_comb begin
    t_prop = g_q.prop[GAIN_W-1]  ? ACC_W'(ops_q.err)   : '0;
    t_int  = g_q.integ[GAIN_W-1] ? ACC_W'(ops_q.sum)   : '0;
    t_der  = g_q.deriv[GAIN_W-1] ? ACC_W'(ops_q.deriv) : '0;
    acc_d  = (acc_q <<< 1) + t_prop + t_int + t_der;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(GAIN_W);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      g_q   <= gains_i;
      ops_q <= ops_i;
      acc_q <= '0;
    end else if (busy_q && cnt_q != '0) begin
      g_q.prop  <= g_q.prop  << 1;
      g_q.integ <= g_q.integ << 1;
      g_q.deriv <= g_q.deriv << 1;
      acc_q     <= acc_d;
    end
  end

  assign done_o = busy_q && (cnt_q == '0);
  assign acc_o  = acc_q;

endmodule

// ----- hw/rtl/pid_temperature_regulator_top.sv -----
// PID heater regulator, one sensor word per control tick.
// Input stream: tdata[11:0] is the raw sensor sample, tuser[0] is restart,
// which clears the error sum and the previous error before the word is used.
// Output stream: one word per input word, drive power (Q0.16, 65536 = full)
// and the converted temperature (signed Q8.8).
// Config port: write cfg_data_i to register cfg_idx_i when cfg_we_i is high
// (0 setpoint, 1..3 P/I/D gains, 4 integral limit, 5 power cap); write only
// while no word is in flight.
// From input acceptance to output tvalid: the bit-serial divider converts
// the sample, error and sum are registered, the shift-add unit is loaded
// and forms the three gain products, the output state is entered, then the
// output load. tready comes back together with tvalid, so a new word is
// taken only after the last one is through. The result waits in an
// output register; the next input word is taken while it waits, and the new
// result stalls only if the old one is still not taken when it is ready.
// Reset: error sum and previous error go to zero, registers to their defaults.
module pid_temperature_regulator_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [pidtr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pidtr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [pidtr_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // adc_sample, zero pad
  input  logic [pidtr_pkg::S_TUSER_W-1:0]  s_axis_tuser,  // restart
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [pidtr_pkg::M_TDATA_W-1:0]  m_axis_tdata   // drive_power, measured_temp, pad
);
  import pidtr_pkg::*;

  logic [SP_W-1:0]   sp_q;
  gains_t            gains_q;
  logic [LIM_W-1:0]  lim_q;
  logic [PWR_W-1:0]  cap_q;

  state_e state_q, state_d;

  logic                     in_acc;
  logic                     div_done;
  logic [QUO_W-1:0]         div_quot;
  logic                     mac_go_q;
  logic                     mac_done;
  logic signed [ACC_W-1:0]  mac_acc;
  mac_ops_t                 ops_q;

  logic signed [SUM_W-1:0]  sum_q;
  logic signed [ERR_W-1:0]  last_q;
  logic signed [TEMP_W-1:0] temp_q, temp_d;
  logic signed [WIDE_W-1:0] err_w, sum_w, der_w, lim_w;
  logic signed [ERR_W-1:0]  err_d;
  logic signed [SUM_W-1:0]  sum_d;

  logic [ACC_W-2:0]         rnd;
  logic [ACC_W-2-PWR_SHIFT:0] pwr_full;
  logic [PWR_W-1:0]         pwr_sat, pwr_d;
  logic                     out_load;
  logic                     m_valid_q;
  logic [PWR_W-1:0]         out_pwr_q;
  logic [TEMP_W-1:0]        out_temp_q;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q          <= '0;
      gains_q.prop  <= GAIN_W'(3277);
      gains_q.integ <= GAIN_W'(66);
      gains_q.deriv <= GAIN_W'(655);
      lim_q         <= LIM_W'(12800);
      cap_q         <= PWR_W'(32768);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SETPOINT:  sp_q          <= cfg_data_i[SP_W-1:0];
        CFG_GAIN_PROP: gains_q.prop  <= cfg_data_i[GAIN_W-1:0];
        CFG_GAIN_INT:  gains_q.integ <= cfg_data_i[GAIN_W-1:0];
        CFG_GAIN_DER:  gains_q.deriv <= cfg_data_i[GAIN_W-1:0];
        CFG_INT_LIMIT: lim_q         <= cfg_data_i[LIM_W-1:0];
        CFG_POWER_CAP: cap_q         <= cfg_data_i[PWR_W-1:0];
        default: ;
      endcase
    end
  end

  pidtr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc),
    .num_i   (conv_num(s_axis_tdata[RAW_W-1:0])),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // temperature, error, clamped sum and difference from the quotient
  always_comb begin
    temp_d = TEMP_OFS - TEMP_W'(div_quot);
    err_w  = WIDE_W'({sp_q, 8'b0}) - WIDE_W'(temp_d);
    err_d  = err_w[ERR_W-1:0];
    lim_w  = WIDE_W'(lim_q);
    sum_w  = WIDE_W'(sum_q) + WIDE_W'(err_d);
    if (sum_w > lim_w) begin
      sum_w = lim_w;
    end else if (sum_w < -lim_w) begin
      sum_w = -lim_w;
    end
    sum_d  = sum_w[SUM_W-1:0];
    der_w  = WIDE_W'(err_d) - WIDE_W'(last_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q    <= '0;
      last_q   <= '0;
      mac_go_q <= 1'b0;
    end else begin
      mac_go_q <= 1'b0;
      if (in_acc && s_axis_tuser[0]) begin
        sum_q  <= '0;
        last_q <= '0;
      end else if (state_q == ST_DIV && div_done) begin
        sum_q    <= sum_d;
        last_q   <= err_d;
        mac_go_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DIV && div_done) begin
      temp_q      <= temp_d;
      ops_q.err   <= err_d;
      ops_q.sum   <= sum_d;
      ops_q.deriv <= der_w[DER_W-1:0];
    end
  end

  pidtr_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mac_go_q),
    .gains_i (gains_q),
    .ops_i   (ops_q),
    .done_o  (mac_done),
    .acc_o   (mac_acc)
  );

  // nonpositive sum -> 0, else round to Q0.16, saturate, then cap
  always_comb begin
    rnd      = mac_acc[ACC_W-2:0] + PWR_RND;
    pwr_full = rnd[ACC_W-2:PWR_SHIFT];
    pwr_sat  = (pwr_full > (ACC_W-1-PWR_SHIFT)'(FULL_POWER)) ? FULL_POWER
                                                            : pwr_full[PWR_W-1:0];
    if (mac_acc[ACC_W-1] || mac_acc == '0) begin
      pwr_sat = '0;
    end
    pwr_d = (pwr_sat > cap_q) ? cap_q : pwr_sat;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_acc)   state_d = ST_DIV;
      ST_DIV:  if (div_done) state_d = ST_MUL;
      ST_MUL:  if (mac_done) state_d = ST_OUT;
      ST_OUT:  if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign out_load = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_pwr_q  <= pwr_d;
      out_temp_q <= temp_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {(M_TDATA_W - PWR_W - TEMP_W)'(0), out_temp_q, out_pwr_q};

endmodule

// ----- hw/rtl/pidtr_checker.sv -----
module pidtr_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [pidtr_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import pidtr_pkg::*;

  // one word in flight: no second acceptance right behind the first
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while a word is in flight");

  a_power_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[PWR_W-1:0] <= FULL_POWER))
    else $error("drive power above full scale");

  a_temp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      ($signed(m_axis_tdata[PWR_W+TEMP_W-1:PWR_W]) >= TEMP_MIN) &&
      ($signed(m_axis_tdata[PWR_W+TEMP_W-1:PWR_W]) <= TEMP_MAX))
    else $error("measured temperature out of range");

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("output word dropped while stalled");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("output word changed while stalled");

endmodule

bind pid_temperature_regulator_top pidtr_checker u_pidtr_checker (.*);
